// ===== rtl/phc_pkg.sv =====
// shared types and constants for the point to hex cell lookup
package phc_pkg;

  localparam int unsigned MaxBoard  = 16;
  localparam int unsigned BoardW    = 5;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned LenW      = 12;
  localparam int unsigned RecipW    = 24;
  localparam int unsigned CellW     = 4;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned BoundXW   = 18;
  localparam int unsigned BoundYW   = 19;

  localparam logic [CfgIdxW-1:0] RegBoardSize    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOriginX      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOriginY      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSideLength   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHalfWidth    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegInvHalfWidth = 3'd5;
  localparam logic [CfgIdxW-1:0] RegInvRowPitch  = 3'd6;

  typedef struct packed {
    logic [BoardW-1:0]  board_n;
    logic [CoordW-1:0]  origin_x;
    logic [CoordW-1:0]  origin_y;
    logic [LenW-1:0]    side_length;
    logic [LenW-1:0]    half_width;
    logic [RecipW-1:0]  inv_half_width;
    logic [RecipW-1:0]  inv_row_pitch;
    logic [BoundXW-1:0] bound_x;
    logic [BoundYW-1:0] bound_y2;
  } cfg_t;

  typedef struct packed {
    logic [CellW-1:0] cell_row;
    logic [CellW-1:0] cell_col;
    logic             off_board;
  } result_t;

endpackage

// ===== rtl/phc_cfg.sv =====
// configuration registers and registered bounding box limits
module phc_cfg import phc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  logic [BoardW-1:0]  board_size_q;
  logic [CoordW-1:0]  origin_x_q;
  logic [CoordW-1:0]  origin_y_q;
  logic [LenW-1:0]    side_length_q;
  logic [LenW-1:0]    half_width_q;
  logic [RecipW-1:0]  inv_half_width_q;
  logic [RecipW-1:0]  inv_row_pitch_q;
  logic [BoundXW-1:0] bound_x_q, bound_x_d;
  logic [BoundYW-1:0] bound_y2_q, bound_y2_d;
  logic [BoardW-1:0]  board_n;
  logic [6:0]         three_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_size_q     <= BoardW'(11);
      origin_x_q       <= '0;
      origin_y_q       <= '0;
      side_length_q    <= LenW'(256);
      half_width_q     <= LenW'(222);
      inv_half_width_q <= RecipW'(75674);
      inv_row_pitch_q  <= RecipW'(43690);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegBoardSize:    board_size_q     <= cfg_data_i[BoardW-1:0];
        RegOriginX:      origin_x_q       <= cfg_data_i[CoordW-1:0];
        RegOriginY:      origin_y_q       <= cfg_data_i[CoordW-1:0];
        RegSideLength:   side_length_q    <= cfg_data_i[LenW-1:0];
        RegHalfWidth:    half_width_q     <= cfg_data_i[LenW-1:0];
        RegInvHalfWidth: inv_half_width_q <= cfg_data_i[RecipW-1:0];
        RegInvRowPitch:  inv_row_pitch_q  <= cfg_data_i[RecipW-1:0];
        default: ;
      endcase
    end
  end

  // board size clamped to the largest board
  assign board_n = (board_size_q > BoardW'(MaxBoard)) ? BoardW'(MaxBoard) : board_size_q;
  assign three_n = 7'({2'b0, board_n} * 7'd3);

  // x limit (3n-1)*h + x0, y limit doubled (3n+1)*s + 2*y0
  assign bound_x_d  = BoundXW'(7'(three_n - 7'd1) * {6'b0, half_width_q})
                    + BoundXW'(origin_x_q);
  assign bound_y2_d = BoundYW'(7'(three_n + 7'd1) * {7'b0, side_length_q})
                    + BoundYW'({origin_y_q, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_x_q  <= '0;
      bound_y2_q <= '0;
    end else begin
      bound_x_q  <= bound_x_d;
      bound_y2_q <= bound_y2_d;
    end
  end

  assign cfg_o.board_n        = board_n;
  assign cfg_o.origin_x       = origin_x_q;
  assign cfg_o.origin_y       = origin_y_q;
  assign cfg_o.side_length    = side_length_q;
  assign cfg_o.half_width     = half_width_q;
  assign cfg_o.inv_half_width = inv_half_width_q;
  assign cfg_o.inv_row_pitch  = inv_row_pitch_q;
  assign cfg_o.bound_x        = bound_x_q;
  assign cfg_o.bound_y2       = bound_y2_q;

endmodule

// ===== rtl/phc_locate.sv =====
// box test, reciprocal scaling, lattice floor and centre selection
module phc_locate import phc_pkg::*; (
  input  cfg_t              cfg_i,
  input  logic [CoordW-1:0] point_x_i,
  input  logic [CoordW-1:0] point_y_i,
  output result_t           result_o
);

  logic               out_box;
  logic signed [17:0] dx, dy;
  logic signed [42:0] prod_x, prod_y;
  logic signed [18:0] xc, yc;
  logic [15:0]        fx, fy;
  logic [18:0]        fy3;
  logic [18:0]        sum_even;
  logic               pick_low;
  logic signed [19:0] xh, yh;
  logic signed [20:0] diff;
  logic signed [20:0] col;
  logic signed [20:0] n_ext;
  logic               in_cells;

  assign out_box = (cfg_i.board_n == '0)
                 || (point_x_i < cfg_i.origin_x)
                 || (BoundXW'(point_x_i) > cfg_i.bound_x)
                 || (point_y_i < cfg_i.origin_y)
                 || (BoundYW'({point_y_i, 1'b0}) > cfg_i.bound_y2);

  assign dx = $signed({2'b0, point_x_i}) - $signed({2'b0, cfg_i.origin_x})
            - $signed({6'b0, cfg_i.half_width});
  assign dy = $signed({2'b0, point_y_i}) - $signed({2'b0, cfg_i.origin_y})
            - $signed({6'b0, cfg_i.side_length});

  assign prod_x = dx * $signed({1'b0, cfg_i.inv_half_width});
  assign prod_y = dy * $signed({1'b0, cfg_i.inv_row_pitch});

  // drop 8 bits, then split integer and 16-bit fraction
  assign xc = prod_x[42:24];
  assign yc = prod_y[42:24];
  assign fx = prod_x[23:8];
  assign fy = prod_y[23:8];

  assign fy3      = {3'b0, fy} + {2'b0, fy, 1'b0};
  assign sum_even = fy3 + {3'b0, fx};

  always_comb begin
    if ((xc[0] ^ yc[0]) == 1'b0) begin
      pick_low = sum_even < 19'h20000;
      xh = pick_low ? 20'(xc) : 20'(xc) + 20'sd1;
      yh = pick_low ? 20'(yc) : 20'(yc) + 20'sd1;
    end else begin
      pick_low = fy3 < ({3'b0, fx} + 19'h10000);
      xh = pick_low ? 20'(xc) + 20'sd1 : 20'(xc);
      yh = pick_low ? 20'(yc) : 20'(yc) + 20'sd1;
    end
  end

  // column halves the difference, rounding toward zero
  assign diff  = 21'(xh) - 21'(yh);
  assign col   = diff[20] ? ((diff + 21'sd1) >>> 1) : (diff >>> 1);
  assign n_ext = $signed({16'b0, cfg_i.board_n});

  assign in_cells = !yh[19] && (21'(yh) < n_ext) && !col[20] && (col < n_ext);

  always_comb begin
    result_o = '0;
    result_o.off_board = 1'b1;
    if (!out_box && in_cells) begin
      result_o.cell_row  = cfg_i.board_n[CellW-1:0] - CellW'(1) - yh[CellW-1:0];
      result_o.cell_col  = col[CellW-1:0];
      result_o.off_board = 1'b0;
    end
  end

endmodule

// ===== rtl/point_to_hex_cell.sv =====
// top level: point stream in, hex cell stream out
// One point per clock while the output is not stalled. A point accepted on
// s_axis is registered, mapped by combinational logic (box test, one 18x25
// multiply per axis, floor and centre pick) and its cell is captured in the
// output register that drives m_axis_tvalid. A stalled output beat holds the
// point in the input register and drops s_axis_tready.
// The bounding box limits are registered from the configuration, so after a
// configuration write they lag the other configuration fields.
module point_to_hex_cell import phc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // point_x, point_y
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // cell_row, cell_col
  output logic                m_axis_tuser    // off_board
);

  cfg_t              cfg;
  result_t           result;
  logic              in_valid_q;
  logic [CoordW-1:0] point_x_q, point_y_q;
  logic              out_valid_q;
  result_t           result_q;
  logic              out_free;

  phc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      point_x_q <= s_axis_tdata[15:0];
      point_y_q <= s_axis_tdata[31:16];
    end
  end

  phc_locate u_locate (
    .cfg_i     (cfg),
    .point_x_i (point_x_q),
    .point_y_i (point_y_q),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && in_valid_q) begin
      result_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {result_q.cell_col, result_q.cell_row};
  assign m_axis_tuser  = result_q.off_board;

endmodule
